// ===== src/ptw_pkg.sv =====
// Shared types for the page table walker: controller states, datapath
// commands and the datapath status bundle. No dependencies.
`timescale 1ns / 1ps

package ptw_pkg;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_WRD, ST_WEV, ST_SRD, ST_SEV, ST_SLEAF, ST_SFIN,
        ST_SRET, ST_UNLINK, ST_TOP, ST_ZERO, ST_CPRD, ST_CPWR, ST_EUNL,
        ST_LINK, ST_PCHK, ST_PDEC, ST_RSRD, ST_RSWR, ST_ACC, ST_FIN
    } ptw_state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLR, CMD_LOAD, CMD_WALK_RD, CMD_WALK_NEXT, CMD_SCAN_INIT,
        CMD_SCAN_RD, CMD_SCAN_ADV, CMD_LEAF_DIFF, CMD_LEAF_UPD, CMD_PUSH,
        CMD_FIN_NODE, CMD_SCAN_RET, CMD_UNLINK, CMD_TOP, CMD_ZERO, CMD_EVC_RD,
        CMD_EVC_WR, CMD_EVC_UNL, CMD_LINK, CMD_VCHK, CMD_RST_RD, CMD_RST_WR,
        CMD_ACCESS, CMD_OUT
    } ptw_cmd_t;

    typedef struct packed {
        logic in_range;
        logic init_last;
        logic ent_zero;
        logic leaf;
        logic off_last;
        logic node_empty;
        logic dep_zero;
        logic top_room;
        logic best_in_back;
        logic cnt_last;
        logic lvl_last;
        logic restore;
        logic out_free;
    } ptw_stat_t;

endpackage

// ===== src/ptw_ctrl.sv =====
// Sequencer for the page table walker: walk, scan, allocate, evict, restore.
// Depends on ptw_pkg; drives ptw_dp through command and status signals.
`timescale 1ns / 1ps

module ptw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptw_pkg::ptw_stat_t  stat,
    output ptw_pkg::ptw_cmd_t   cmd
);

    ptw_pkg::ptw_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptw_pkg::ST_INIT: begin
                if (stat.init_last) state_next = ptw_pkg::ST_IDLE;
            end
            ptw_pkg::ST_IDLE: begin
                if (s_valid) state_next = stat.in_range ? ptw_pkg::ST_WRD : ptw_pkg::ST_FIN;
            end
            ptw_pkg::ST_WRD: state_next = ptw_pkg::ST_WEV;
            ptw_pkg::ST_WEV: begin
                if (stat.ent_zero) state_next = ptw_pkg::ST_SRD;
                else state_next = stat.lvl_last ? ptw_pkg::ST_PCHK : ptw_pkg::ST_WRD;
            end
            ptw_pkg::ST_SRD: state_next = ptw_pkg::ST_SEV;
            ptw_pkg::ST_SEV: begin
                if (stat.ent_zero) state_next = stat.off_last ? ptw_pkg::ST_SFIN : ptw_pkg::ST_SRD;
                else if (stat.leaf) state_next = ptw_pkg::ST_SLEAF;
                else state_next = ptw_pkg::ST_SRD;
            end
            ptw_pkg::ST_SLEAF: state_next = stat.off_last ? ptw_pkg::ST_SFIN : ptw_pkg::ST_SRD;
            ptw_pkg::ST_SFIN: begin
                if (stat.node_empty)
                    state_next = stat.dep_zero ? ptw_pkg::ST_LINK : ptw_pkg::ST_UNLINK;
                else
                    state_next = stat.dep_zero ? ptw_pkg::ST_TOP : ptw_pkg::ST_SRET;
            end
            ptw_pkg::ST_SRET: state_next = stat.off_last ? ptw_pkg::ST_SFIN : ptw_pkg::ST_SRD;
            ptw_pkg::ST_UNLINK: state_next = ptw_pkg::ST_LINK;
            ptw_pkg::ST_TOP: begin
                if (stat.top_room) state_next = ptw_pkg::ST_ZERO;
                else state_next = stat.best_in_back ? ptw_pkg::ST_CPRD : ptw_pkg::ST_EUNL;
            end
            ptw_pkg::ST_ZERO: begin
                if (stat.cnt_last) state_next = ptw_pkg::ST_LINK;
            end
            ptw_pkg::ST_CPRD: state_next = ptw_pkg::ST_CPWR;
            ptw_pkg::ST_CPWR: state_next = stat.cnt_last ? ptw_pkg::ST_EUNL : ptw_pkg::ST_CPRD;
            ptw_pkg::ST_EUNL: state_next = ptw_pkg::ST_ZERO;
            ptw_pkg::ST_LINK: state_next = stat.lvl_last ? ptw_pkg::ST_PCHK : ptw_pkg::ST_WRD;
            ptw_pkg::ST_PCHK: state_next = ptw_pkg::ST_PDEC;
            ptw_pkg::ST_PDEC: state_next = stat.restore ? ptw_pkg::ST_RSRD : ptw_pkg::ST_ACC;
            ptw_pkg::ST_RSRD: state_next = ptw_pkg::ST_RSWR;
            ptw_pkg::ST_RSWR: state_next = stat.cnt_last ? ptw_pkg::ST_ACC : ptw_pkg::ST_RSRD;
            ptw_pkg::ST_ACC: state_next = ptw_pkg::ST_FIN;
            ptw_pkg::ST_FIN: begin
                if (stat.out_free) state_next = ptw_pkg::ST_IDLE;
            end
            default: state_next = ptw_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = ptw_pkg::CMD_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            ptw_pkg::ST_INIT: cmd = ptw_pkg::CMD_CLR;
            ptw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = ptw_pkg::CMD_LOAD;
            end
            ptw_pkg::ST_WRD: cmd = ptw_pkg::CMD_WALK_RD;
            ptw_pkg::ST_WEV: begin
                cmd = stat.ent_zero ? ptw_pkg::CMD_SCAN_INIT : ptw_pkg::CMD_WALK_NEXT;
            end
            ptw_pkg::ST_SRD: cmd = ptw_pkg::CMD_SCAN_RD;
            ptw_pkg::ST_SEV: begin
                if (stat.ent_zero) cmd = ptw_pkg::CMD_SCAN_ADV;
                else if (stat.leaf) cmd = ptw_pkg::CMD_LEAF_DIFF;
                else cmd = ptw_pkg::CMD_PUSH;
            end
            ptw_pkg::ST_SLEAF: cmd = ptw_pkg::CMD_LEAF_UPD;
            ptw_pkg::ST_SFIN: cmd = ptw_pkg::CMD_FIN_NODE;
            ptw_pkg::ST_SRET: cmd = ptw_pkg::CMD_SCAN_RET;
            ptw_pkg::ST_UNLINK: cmd = ptw_pkg::CMD_UNLINK;
            ptw_pkg::ST_TOP: cmd = ptw_pkg::CMD_TOP;
            ptw_pkg::ST_ZERO: cmd = ptw_pkg::CMD_ZERO;
            ptw_pkg::ST_CPRD: cmd = ptw_pkg::CMD_EVC_RD;
            ptw_pkg::ST_CPWR: cmd = ptw_pkg::CMD_EVC_WR;
            ptw_pkg::ST_EUNL: cmd = ptw_pkg::CMD_EVC_UNL;
            ptw_pkg::ST_LINK: cmd = ptw_pkg::CMD_LINK;
            ptw_pkg::ST_PCHK: cmd = ptw_pkg::CMD_VCHK;
            ptw_pkg::ST_PDEC: cmd = ptw_pkg::CMD_NONE;
            ptw_pkg::ST_RSRD: cmd = ptw_pkg::CMD_RST_RD;
            ptw_pkg::ST_RSWR: cmd = ptw_pkg::CMD_RST_WR;
            ptw_pkg::ST_ACC: cmd = ptw_pkg::CMD_ACCESS;
            ptw_pkg::ST_FIN: begin
                if (stat.out_free) cmd = ptw_pkg::CMD_OUT;
            end
            default: cmd = ptw_pkg::CMD_NONE;
        endcase
    end

endmodule

// ===== src/ptw_dp.sv =====
// Datapath of the page table walker: frame memory, backing store, scan stack,
// eviction candidate and output register. Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_dp #(
    parameter int OFFSET_BITS = 4,
    parameter int TREE_LEVELS = 2,
    parameter int FRAME_COUNT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptw_pkg::ptw_cmd_t   cmd,
    output ptw_pkg::ptw_stat_t  stat,
    input  logic                s_operation,
    input  logic [15:0]         s_virtual_address,
    input  logic signed [31:0]  s_write_value,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [31:0]  m_read_value,
    output logic                m_status,
    output logic [5:0]          m_data_frame
);

    localparam int OB        = OFFSET_BITS;
    localparam int TL        = TREE_LEVELS;
    localparam int PW        = 1 << OB;
    localparam int PBITS     = OB * TL;
    localparam int VBITS     = OB * (TL + 1);
    localparam int BACK_BITS = (VBITS < 16) ? VBITS : 16;
    localparam int BPBITS    = BACK_BITS - OB;
    localparam int BPAGES    = 1 << BPBITS;
    localparam int BWORDS    = 1 << BACK_BITS;
    localparam int FBITS     = $clog2(FRAME_COUNT);
    localparam int AW        = FBITS + OB;
    localparam int LBITS     = (TL > 1) ? $clog2(TL) : 1;
    localparam int CBITS     = (OB > BPBITS) ? OB : BPBITS;

    logic [31:0] frame_mem [FRAME_COUNT * PW];
    logic [31:0] back_mem  [BWORDS];
    logic        valid_mem [BPAGES];

    logic [31:0]       rd_reg, brd_reg, wv_reg;
    logic              vrd_reg, op_reg, range_reg, fresh_reg;
    logic [OB-1:0]     off_reg, cnt_reg;
    logic [PBITS-1:0]  page_reg, best_dist_reg, best_page_reg, diff_reg;
    logic [LBITS-1:0]  lvl_reg, dep_reg;
    logic [FBITS-1:0]  node_reg, pend_reg, best_frame_reg, best_table_reg;
    logic [CBITS-1:0]  icnt_reg;

    // scan stack, one slot per tree level
    logic [FBITS-1:0]  sf_reg [TL];
    logic [PBITS-1:0]  sr_reg [TL];
    logic [OB-1:0]     so_reg [TL];
    logic [FBITS-1:0]  sm_reg [TL];
    logic              su_reg [TL];

    logic                m_valid_reg, m_status_reg;
    logic signed [31:0]  m_rv_reg;
    logic [5:0]          m_df_reg;

    logic [FBITS-1:0]  ent, cur_f, cur_m, node_max, leaf_max, ret_max;
    logic [OB-1:0]     cur_o, idx;
    logic [PBITS-1:0]  cur_r, br, diff_now, cyc_dist;
    logic [PBITS:0]    alt;
    logic              cur_u, better;
    logic [LBITS-1:0]  dep_up;

    logic              fw_en, fr_en, bw_en, br_en, vw_en, vw_data;
    logic [AW-1:0]     fw_addr, fr_addr;
    logic [31:0]       fw_data;
    logic [BACK_BITS-1:0] bw_addr, br_addr;
    logic [BPBITS-1:0] vw_addr;

    // entries at or above the frame count read as empty
    assign ent   = (rd_reg < 32'(FRAME_COUNT)) ? rd_reg[FBITS-1:0] : '0;
    assign cur_f = sf_reg[dep_reg];
    assign cur_o = so_reg[dep_reg];
    assign cur_r = sr_reg[dep_reg];
    assign cur_m = sm_reg[dep_reg];
    assign cur_u = su_reg[dep_reg];
    assign dep_up = dep_reg + 1'b1;

    assign br  = (cur_r << OB) | PBITS'(cur_o);
    assign idx = OB'(page_reg >> (OB * (TL - 1 - int'(lvl_reg))));

    assign node_max = (cur_m > cur_f) ? cur_m : cur_f;
    assign leaf_max = (cur_m > ent) ? cur_m : ent;
    assign ret_max  = (cur_m > pend_reg) ? cur_m : pend_reg;

    // cyclic page distance; the plain difference is registered before the wrap-around fold
    assign diff_now = (br > page_reg) ? (br - page_reg) : (page_reg - br);
    assign alt      = {1'b1, {PBITS{1'b0}}} - {1'b0, diff_reg};
    assign cyc_dist = (alt < {1'b0, diff_reg}) ? PBITS'(alt) : diff_reg;
    assign better   = cyc_dist > best_dist_reg;

    always_comb begin
        stat.in_range     = (s_virtual_address >> VBITS) == '0;
        stat.init_last    = &icnt_reg;
        stat.ent_zero     = ent == '0;
        stat.leaf         = dep_reg == LBITS'(TL - 1);
        stat.off_last     = &cur_o;
        stat.node_empty   = !cur_u && (cur_f != node_reg);
        stat.dep_zero     = dep_reg == '0;
        stat.top_room     = ({1'b0, pend_reg} + 1'b1) < (FBITS + 1)'(FRAME_COUNT);
        stat.best_in_back = (best_page_reg >> BPBITS) == '0;
        stat.cnt_last     = &cnt_reg;
        stat.lvl_last     = lvl_reg == LBITS'(TL - 1);
        stat.restore      = fresh_reg && ((page_reg >> BPBITS) == '0) && vrd_reg;
        stat.out_free     = !m_valid_reg || m_ready;
    end

    // memory port steering
    always_comb begin
        fw_en   = 1'b0;
        fw_addr = {node_reg, off_reg};
        fw_data = '0;
        fr_en   = 1'b0;
        fr_addr = {node_reg, off_reg};
        bw_en   = 1'b0;
        bw_addr = {BPBITS'(best_page_reg), cnt_reg};
        br_en   = 1'b0;
        br_addr = {BPBITS'(page_reg), cnt_reg};
        vw_en   = 1'b0;
        vw_addr = BPBITS'(best_page_reg);
        vw_data = 1'b1;
        case (cmd)
            ptw_pkg::CMD_CLR: begin
                fw_en   = (icnt_reg >> OB) == '0;
                fw_addr = {{FBITS{1'b0}}, OB'(icnt_reg)};
                vw_en   = (icnt_reg >> BPBITS) == '0;
                vw_addr = BPBITS'(icnt_reg);
                vw_data = 1'b0;
            end
            ptw_pkg::CMD_WALK_RD: begin
                fr_en   = 1'b1;
                fr_addr = {node_reg, idx};
            end
            ptw_pkg::CMD_SCAN_RD: begin
                fr_en   = 1'b1;
                fr_addr = {cur_f, cur_o};
            end
            ptw_pkg::CMD_UNLINK: begin
                fw_en   = 1'b1;
                fw_addr = {cur_f, cur_o};
            end
            ptw_pkg::CMD_ZERO: begin
                fw_en   = 1'b1;
                fw_addr = {pend_reg, cnt_reg};
            end
            ptw_pkg::CMD_EVC_RD: begin
                fr_en   = 1'b1;
                fr_addr = {best_frame_reg, cnt_reg};
            end
            ptw_pkg::CMD_EVC_WR: begin
                bw_en = 1'b1;
                vw_en = 1'b1;
            end
            ptw_pkg::CMD_EVC_UNL: begin
                fw_en   = 1'b1;
                fw_addr = {best_table_reg, OB'(best_page_reg)};
            end
            ptw_pkg::CMD_LINK: begin
                fw_en   = 1'b1;
                fw_addr = {node_reg, idx};
                fw_data = 32'(pend_reg);
            end
            ptw_pkg::CMD_RST_RD: br_en = 1'b1;
            ptw_pkg::CMD_RST_WR: begin
                fw_en   = 1'b1;
                fw_addr = {node_reg, cnt_reg};
                fw_data = brd_reg;
            end
            ptw_pkg::CMD_ACCESS: begin
                fw_en   = op_reg;
                fw_data = wv_reg;
                fr_en   = !op_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fw_en) frame_mem[fw_addr] <= fw_data;
        if (fr_en) rd_reg <= frame_mem[fr_addr];
    end

    always_ff @(posedge aclk) begin
        if (bw_en) back_mem[bw_addr] <= rd_reg;
        if (br_en) brd_reg <= back_mem[br_addr];
    end

    always_ff @(posedge aclk) begin
        if (vw_en) valid_mem[vw_addr] <= vw_data;
        if (cmd == ptw_pkg::CMD_VCHK) vrd_reg <= valid_mem[BPBITS'(page_reg)];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icnt_reg    <= '0;
            dep_reg     <= '0;
            lvl_reg     <= '0;
            node_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd == ptw_pkg::CMD_OUT) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (cmd)
                ptw_pkg::CMD_CLR: icnt_reg <= icnt_reg + 1'b1;
                ptw_pkg::CMD_LOAD: begin
                    lvl_reg  <= '0;
                    node_reg <= '0;
                end
                ptw_pkg::CMD_WALK_NEXT: begin
                    node_reg <= ent;
                    if (!stat.lvl_last) lvl_reg <= lvl_reg + 1'b1;
                end
                ptw_pkg::CMD_LINK: begin
                    node_reg <= pend_reg;
                    if (!stat.lvl_last) lvl_reg <= lvl_reg + 1'b1;
                end
                ptw_pkg::CMD_SCAN_INIT: dep_reg <= '0;
                ptw_pkg::CMD_PUSH: dep_reg <= dep_up;
                ptw_pkg::CMD_FIN_NODE: begin
                    if (!stat.dep_zero) dep_reg <= dep_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            ptw_pkg::CMD_LOAD: begin
                op_reg    <= s_operation;
                wv_reg    <= s_write_value;
                off_reg   <= s_virtual_address[OB-1:0];
                page_reg  <= PBITS'(s_virtual_address >> OB);
                range_reg <= stat.in_range;
                fresh_reg <= 1'b0;
            end
            ptw_pkg::CMD_SCAN_INIT: begin
                sf_reg[0]      <= '0;
                sr_reg[0]      <= '0;
                so_reg[0]      <= '0;
                sm_reg[0]      <= '0;
                su_reg[0]      <= 1'b0;
                best_dist_reg  <= '0;
                best_frame_reg <= '0;
                best_page_reg  <= '0;
                best_table_reg <= '0;
            end
            ptw_pkg::CMD_SCAN_ADV: so_reg[dep_reg] <= cur_o + 1'b1;
            ptw_pkg::CMD_LEAF_DIFF: diff_reg <= diff_now;
            ptw_pkg::CMD_LEAF_UPD: begin
                if (better) begin
                    best_dist_reg  <= cyc_dist;
                    best_frame_reg <= ent;
                    best_page_reg  <= br;
                    best_table_reg <= cur_f;
                end
                sm_reg[dep_reg] <= leaf_max;
                su_reg[dep_reg] <= 1'b1;
                so_reg[dep_reg] <= cur_o + 1'b1;
            end
            ptw_pkg::CMD_PUSH: begin
                if (TL > 1) begin
                    sf_reg[dep_up] <= ent;
                    sr_reg[dep_up] <= br;
                    so_reg[dep_up] <= '0;
                    sm_reg[dep_up] <= '0;
                    su_reg[dep_up] <= 1'b0;
                end
            end
            // an empty table is handed back as is; otherwise the highest of its frame and the frames below
            ptw_pkg::CMD_FIN_NODE: pend_reg <= stat.node_empty ? cur_f : node_max;
            ptw_pkg::CMD_SCAN_RET: begin
                sm_reg[dep_reg] <= ret_max;
                su_reg[dep_reg] <= 1'b1;
                so_reg[dep_reg] <= cur_o + 1'b1;
            end
            ptw_pkg::CMD_TOP: begin
                cnt_reg <= '0;
                if (stat.top_room) pend_reg <= pend_reg + 1'b1;
            end
            ptw_pkg::CMD_ZERO: cnt_reg <= cnt_reg + 1'b1;
            ptw_pkg::CMD_EVC_WR: cnt_reg <= cnt_reg + 1'b1;
            ptw_pkg::CMD_EVC_UNL: begin
                pend_reg <= best_frame_reg;
                cnt_reg  <= '0;
            end
            ptw_pkg::CMD_LINK: fresh_reg <= 1'b1;
            ptw_pkg::CMD_VCHK: cnt_reg <= '0;
            ptw_pkg::CMD_RST_WR: cnt_reg <= cnt_reg + 1'b1;
            ptw_pkg::CMD_OUT: begin
                m_status_reg <= range_reg;
                m_rv_reg     <= (range_reg && !op_reg) ? rd_reg : '0;
                m_df_reg     <= range_reg ? 6'(node_reg) : '0;
            end
            default: ;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_rv_reg;
    assign m_status     = m_status_reg;
    assign m_data_frame = m_df_reg;

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == ptw_pkg::CMD_OUT |=> m_valid)
        else $error("result not presented after load");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_data_frame == '0 && m_read_value == '0)
        else $error("failed item carries nonzero payload");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(node_reg) < 32'(FRAME_COUNT))
        else $error("walk node beyond frame count");

    a_dep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == ptw_pkg::CMD_PUSH |-> dep_reg != LBITS'(TL - 1))
        else $error("scan pushed past leaf level");

endmodule

// ===== src/page_table_walker_with_eviction.sv =====
// Paged virtual word memory with a hierarchical page-table walker and frame
// eviction to an internal backing store. One item is one read or write of a
// virtual word; the address's low OFFSET_BITS select the word, the rest is
// split into TREE_LEVELS table indices, most significant first, rooted at
// frame 0. A missing level takes a frame by reusing an empty table found by a
// depth-first scan, else the frame after the highest in use (zeroed), else by
// evicting the mapped page farthest away cyclically (saved if it lies in the
// backing store, unlinked, zeroed); a newly mapped page that was saved before
// is restored. Addresses at or above 2^(OFFSET_BITS*(TREE_LEVELS+1)) return
// status 0 and zeros. Items are processed one at a time by a single-ported
// frame memory. A walk reads and evaluates one table entry per level, then
// does its bookkeeping; each missing level adds a scan that reads and
// evaluates each table entry visited (a mapped leaf entry takes an extra update
// step), up to FRAME_COUNT*2^OFFSET_BITS entries, then a word-by-word zeroing
// of a frame, plus a word-by-word save of an evicted page; a restore copies
// the saved page back word by word. After reset a clearing pass zeroes the
// root table and the saved-page flags before s_ready rises. A finished result
// waits in an output register; the next item is taken once the result is
// delivered or registered.
`timescale 1ns / 1ps

module page_table_walker_with_eviction #(
    parameter int OFFSET_BITS = 4,
    parameter int TREE_LEVELS = 2,
    parameter int FRAME_COUNT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // item in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [15:0]         s_virtual_address,
    input  logic signed [31:0]  s_write_value,
    // result out
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_read_value,
    output logic                m_status,
    output logic [5:0]          m_data_frame
);

    ptw_pkg::ptw_cmd_t  cmd;
    ptw_pkg::ptw_stat_t stat;

    // sequencer: one state per datapath step
    ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories, scan stack and result register
    ptw_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .TREE_LEVELS (TREE_LEVELS),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_operation       (s_operation),
        .s_virtual_address (s_virtual_address),
        .s_write_value     (s_write_value),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_read_value      (m_read_value),
        .m_status          (m_status),
        .m_data_frame      (m_data_frame)
    );

endmodule
